FILE: design/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// Ranging distance package
// Shared status codes and register indexes for the two-way ranging distance unit.
// ----------------------------------------------------------------------------
package dstwr_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOTPOS  = 2'd2,
        ST_LIMIT   = 2'd3
    } t_status;

    localparam int unsigned REG_MM_PER_TICK = 0;
    localparam int unsigned REG_MAX_RANGE   = 1;

endpackage

FILE: design/dstwr_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// STEPS restoring division steps per cell; the numerator/quotient shifts left
// through the cell and the partial remainder moves on to the next cell.
// ----------------------------------------------------------------------------
module dstwr_div_cell #(
    parameter int unsigned NUM_BITS = 112,
    parameter int unsigned DEN_BITS = 43,
    parameter int unsigned STEPS    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ok,
    input  logic [1:0]          i_status,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS:0]   i_rem,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_valid,
    output logic                o_ok,
    output logic [1:0]          o_status,
    output logic [NUM_BITS-1:0] o_num,
    output logic [DEN_BITS:0]   o_rem,
    output logic [DEN_BITS-1:0] o_den
);

    logic [NUM_BITS-1:0] n_num;
    logic [DEN_BITS:0]   n_rem;
    logic [DEN_BITS+1:0] w_trial;

    always_comb begin
        n_num = i_num;
        n_rem = i_rem;
        w_trial = '0;
        for (int k = 0; k < STEPS; k++) begin
            w_trial = {n_rem, n_num[NUM_BITS-1]};
            n_num   = {n_num[NUM_BITS-2:0], 1'b0};
            if (w_trial >= {2'b00, i_den}) begin
                w_trial = w_trial - {2'b00, i_den};
                n_num[0] = 1'b1;
            end
            n_rem = w_trial[DEN_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_ok     <= i_ok;
        o_status <= i_status;
        o_num    <= n_num;
        o_rem    <= n_rem;
        o_den    <= i_den;
    end

endmodule

FILE: design/ds_twr_distance_calc_unit.sv
// ----------------------------------------------------------------------------
// Two-way ranging distance unit
// Channel | Direction | Payload
// in      | input     | six timestamps
// out     | output    | distance_mm, status
// cfg     | APB       | mm_per_tick_q24, max_range_mm
// A new item is taken every cycle unless the output stalls; the divider
// chain of 112/8 = 14 cells sits between the numerator and scale stages.
// A stalled output stops the whole pipeline; reset clears all valid bits.
// ----------------------------------------------------------------------------
module ds_twr_distance_calc_unit
    import dstwr_pkg::*;
#(
    parameter int unsigned STAMP_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [39:0]           i_poll_sent,
    input  logic [39:0]           i_poll_seen,
    input  logic [39:0]           i_reply_sent,
    input  logic [39:0]           i_reply_seen,
    input  logic [39:0]           i_last_sent,
    input  logic [39:0]           i_last_seen,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [20:0]    o_distance_mm,
    output logic [1:0]            o_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned SB    = STAMP_BITS;
    localparam int unsigned DB    = SB + 3;
    localparam int unsigned NUMW  = 112;
    localparam int unsigned STEPS = 8;
    localparam int unsigned CELLS = NUMW / STEPS;

    logic [31:0] r_mm;
    logic [19:0] r_max;
    logic        w_adv;

    assign pready = 1'b1;
    assign w_adv  = !o_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm  <= 32'd78714738;
            r_max <= 20'd100000;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'(REG_MAX_RANGE)) begin
                r_max <= pwdata[19:0];
            end else begin
                r_mm <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[2] == 1'(REG_MAX_RANGE)) begin
            prdata = {12'd0, r_max};
        end else begin
            prdata = r_mm;
        end
    end

    // Stage 1: intervals.
    logic          r1_v;
    logic [SB-1:0] r1_ra, r1_rb, r1_da, r1_db;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
        if (w_adv) begin
            r1_ra <= SB'(i_reply_seen) - SB'(i_poll_sent);
            r1_rb <= SB'(i_last_seen) - SB'(i_reply_sent);
            r1_da <= SB'(i_last_sent) - SB'(i_reply_seen);
            r1_db <= SB'(i_reply_sent) - SB'(i_poll_seen);
        end
    end

    // Stage 2: partial products (each half at most SB x SB/2).
    localparam int unsigned HB = SB / 2;
    localparam int unsigned HT = SB - HB;
    logic            r2_v;
    logic [DB-1:0]   r2_den;
    logic [SB+HB-1:0] r2_al, r2_bl;
    logic [SB+HT-1:0] r2_ah, r2_bh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_den <= DB'(r1_ra) + DB'(r1_rb) + DB'(r1_da) + DB'(r1_db);
            r2_al  <= r1_ra * r1_rb[HB-1:0];
            r2_ah  <= r1_ra * r1_rb[SB-1:HB];
            r2_bl  <= r1_da * r1_db[HB-1:0];
            r2_bh  <= r1_da * r1_db[SB-1:HB];
        end
    end

    // Stage 3: full products.
    logic          r3_v;
    logic [DB-1:0] r3_den;
    logic [2*SB-1:0] r3_pa, r3_pb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
        if (w_adv) begin
            r3_den <= r2_den;
            r3_pa  <= (2*SB)'(r2_al) + ((2*SB)'(r2_ah) << HB);
            r3_pb  <= (2*SB)'(r2_bl) + ((2*SB)'(r2_bh) << HB);
        end
    end

    // Stage 4: numerator and early status.
    logic            r4_v, r4_ok;
    logic [1:0]      r4_st;
    logic [DB-1:0]   r4_den;
    logic [NUMW-1:0] r4_num;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
        end
        if (w_adv) begin
            r4_den <= (r3_den == '0) ? DB'(1) : r3_den;
            r4_num <= NUMW'({r3_pa - r3_pb, 16'd0});
            if (r3_den == '0) begin
                r4_ok <= 1'b0;
                r4_st <= ST_ZERO;
            end else if (r3_pa <= r3_pb) begin
                r4_ok <= 1'b0;
                r4_st <= ST_NOTPOS;
            end else begin
                r4_ok <= 1'b1;
                r4_st <= ST_OK;
            end
        end
    end

    // Divider cell chain.
    logic            c_v  [CELLS+1];
    logic            c_ok [CELLS+1];
    logic [1:0]      c_st [CELLS+1];
    logic [NUMW-1:0] c_num[CELLS+1];
    logic [DB:0]     c_rem[CELLS+1];
    logic [DB-1:0]   c_den[CELLS+1];

    assign c_v[0]   = r4_v;
    assign c_ok[0]  = r4_ok;
    assign c_st[0]  = r4_st;
    assign c_num[0] = r4_num;
    assign c_rem[0] = '0;
    assign c_den[0] = r4_den;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic            w_v, w_ok;
        logic [1:0]      w_st;
        logic [NUMW-1:0] w_num;
        logic [DB:0]     w_rem;
        logic [DB-1:0]   w_den;
        dstwr_div_cell #(.NUM_BITS(NUMW), .DEN_BITS(DB), .STEPS(STEPS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c_v[g] && w_adv),
            .i_ok(c_ok[g]), .i_status(c_st[g]), .i_num(c_num[g]), .i_rem(c_rem[g]),
            .i_den(c_den[g]), .o_valid(w_v), .o_ok(w_ok), .o_status(w_st),
            .o_num(w_num), .o_rem(w_rem), .o_den(w_den)
        );
        logic r_hv, r_hok;
        logic [1:0] r_hst;
        logic [NUMW-1:0] r_hnum;
        logic [DB:0] r_hrem;
        logic [DB-1:0] r_hden;
        logic r_fresh;
        // Holding register keeps a cell's result while the output is stalled.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fresh <= 1'b0;
                r_hv    <= 1'b0;
            end else begin
                r_fresh <= w_adv;
                if (r_fresh) begin
                    r_hv <= w_v;
                end
            end
            if (r_fresh) begin
                r_hok <= w_ok; r_hst <= w_st; r_hnum <= w_num;
                r_hrem <= w_rem; r_hden <= w_den;
            end
        end
        assign c_v[g+1]   = r_fresh ? w_v   : r_hv;
        assign c_ok[g+1]  = r_fresh ? w_ok  : r_hok;
        assign c_st[g+1]  = r_fresh ? w_st  : r_hst;
        assign c_num[g+1] = r_fresh ? w_num : r_hnum;
        assign c_rem[g+1] = r_fresh ? w_rem : r_hrem;
        assign c_den[g+1] = r_fresh ? w_den : r_hden;
    end

    // Stage 5: scale partial products.
    logic         r5_v, r5_ok, r5_big, r5_zero;
    logic [1:0]   r5_st;
    logic [63:0]  r5_plo, r5_phi;
    logic [NUMW-1:0] w_q;
    assign w_q = c_num[CELLS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= c_v[CELLS];
        end
        if (w_adv) begin
            r5_ok   <= c_ok[CELLS];
            r5_st   <= c_st[CELLS];
            r5_zero <= (w_q == '0) || (r_mm == '0);
            r5_big  <= (w_q[NUMW-1:64] != '0);
            r5_plo  <= w_q[31:0] * r_mm;
            r5_phi  <= w_q[63:32] * r_mm;
        end
    end

    // Stage 6: sum and limit.
    logic         r6_v;
    logic [1:0]   r6_st;
    logic [63:0]  r6_low;
    logic [64:0]  w_low;
    logic [31:0]  w_hi;
    assign w_low = {1'b0, r5_plo} + {1'b0, r5_phi[31:0], 32'd0};
    assign w_hi  = r5_phi[63:32] + {31'd0, w_low[64]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
        if (w_adv) begin
            r6_low <= w_low[63:0];
            if (!r5_ok) begin
                r6_st <= r5_st;
            end else if (r5_zero) begin
                r6_st <= ST_NOTPOS;
            end else if (r5_big || w_hi != '0 || w_low[63:0] > {4'd0, r_max, 40'd0}) begin
                r6_st <= ST_LIMIT;
            end else begin
                r6_st <= ST_OK;
            end
        end
    end

    // Output register.
    logic [63:0] w_rnd;
    assign w_rnd = r6_low + 64'h80_0000_0000;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r6_v;
        end
        if (w_adv) begin
            o_status <= r6_st;
            o_distance_mm <= (r6_st == ST_OK) ? $signed(w_rnd[60:40]) : -21'sd1;
        end
    end

endmodule
